// File: hdl/fcps_pkg.sv
`timescale 1ns / 1ps

package fcps_pkg;

  localparam int POS_W       = 11;
  localparam int CNT_W       = 32;
  localparam int DEF_ENTRIES = 1024;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic {
    REQ_INC   = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

endpackage

// File: hdl/fcps_ram.sv
`timescale 1ns / 1ps

module fcps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/fenwick_count_prefix_sum_core.sv
`timescale 1ns / 1ps

// Fenwick tree of saturating event counters, zero-indexed.
// Drive req_type and position with start high while busy is low to hand
// in one item. An increment (REQ_INC) bumps every node on the upward walk
// and gives no result; a query (REQ_QUERY) sums the nodes on the downward
// walk and puts prefix_count on the ports, with done high for one cycle.
// Busy stays high while a walk visits its tree nodes; a query's done
// strobe comes in the cycle after the last node. A walk visits at most
// about log2(ENTRIES)+1 nodes (11 for 1024 entries). The node store is
// one memory with a registered read; each cycle reads the next node
// while an increment writes the current one back, so one node per cycle.
// A negative query answers 0 in the cycle after accept; an out-of-range or
// negative increment is dropped and busy stays low.
// Reset (rst, synchronous) starts a clearing pass that zeroes every
// entry of the store; busy is high throughout and no item is accepted.
// The receiver cannot stall: results are taken in the cycle of done.
module fenwick_count_prefix_sum_core #(
  parameter int ENTRIES = fcps_pkg::DEF_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       req_type,
  input  logic [fcps_pkg::POS_W-1:0] position,
  output logic                       done,
  output logic [fcps_pkg::CNT_W-1:0] prefix_count
);

  import fcps_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int PW = (IW + 2 > POS_W + 1) ? IW + 2 : POS_W + 1;
  localparam logic signed [PW-1:0] ENT_S   = PW'(ENTRIES);
  localparam logic [IW:0]          ENT_U   = (IW+1)'(ENTRIES);
  localparam logic [IW-1:0]        LAST_IX = IW'(ENTRIES - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK
  } state_t;

  state_t          state;
  logic            op;
  logic [IW-1:0]   idx;
  logic [IW-1:0]   clear_idx;
  logic [CNT_W-1:0] sum;

  logic              accept;
  logic signed [PW-1:0] pos_ext;
  logic              pos_neg;
  logic              pos_high;
  logic [IW-1:0]     start_idx;

  logic [IW:0]       idx_w;
  logic [IW:0]       idx_inc;
  logic [IW:0]       up_next;
  logic [IW-1:0]     down_base;
  logic              more;
  logic [IW-1:0]     next_idx;
  logic [CNT_W:0]    sum_wide;
  logic [CNT_W-1:0]  sum_next;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [CNT_W-1:0]  ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic [CNT_W-1:0]  ram_rdata;

  assign accept   = start && !busy;
  assign pos_ext  = {{(PW-POS_W){position[POS_W-1]}}, position};
  assign pos_neg  = pos_ext[PW-1];
  assign pos_high = pos_ext >= ENT_S;

  // clamp a query beyond the top to the last entry
  assign start_idx = pos_high ? LAST_IX : pos_ext[IW-1:0];

  always_comb begin
    idx_w     = {1'b0, idx};
    idx_inc   = idx_w + (IW+1)'(1);
    up_next   = idx_w | idx_inc;
    down_base = IW'(idx_w & idx_inc);
    if (op == REQ_INC) begin
      more     = up_next < ENT_U;
      next_idx = up_next[IW-1:0];
    end else begin
      more     = down_base != '0;
      next_idx = down_base - IW'(1);
    end
    sum_wide = {1'b0, sum} + {1'b0, ram_rdata};
    sum_next = sum_wide[CNT_W] ? CNT_MAX : sum_wide[CNT_W-1:0];
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = (ram_rdata == CNT_MAX) ? ram_rdata : ram_rdata + CNT_W'(1);
    ram_raddr = idx;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clear_idx;
        ram_wdata = '0;
      end
      S_IDLE: begin
        ram_raddr = start_idx;
      end
      S_WALK: begin
        ram_we    = (op == REQ_INC);
        ram_raddr = next_idx;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  fcps_ram #(
    .WIDTH (CNT_W),
    .DEPTH (ENTRIES)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      busy      <= 1'b1;
      done      <= 1'b0;
      clear_idx <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          done      <= 1'b0;
          clear_idx <= clear_idx + IW'(1);
          if (clear_idx == LAST_IX) begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        S_IDLE: begin
          // a negative query answers without a walk
          done <= accept && (req_type == REQ_QUERY) && pos_neg;
          if (accept) begin
            op  <= req_type;
            idx <= start_idx;
            sum <= '0;
            if (req_type == REQ_QUERY) begin
              if (pos_neg) begin
                prefix_count <= '0;
              end else begin
                state <= S_WALK;
                busy  <= 1'b1;
              end
            end else if (!pos_neg && !pos_high) begin
              state <= S_WALK;
              busy  <= 1'b1;
            end
          end
        end
        S_WALK: begin
          done <= !more && (op == REQ_QUERY);
          sum  <= sum_next;
          idx  <= next_idx;
          if (!more) begin
            state <= S_IDLE;
            busy  <= 1'b0;
            if (op == REQ_QUERY) begin
              prefix_count <= sum_next;
            end
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule
